[design/bfla_pkg.sv]
// bfla_pkg: shared types and constants of the buffer free-list allocator
// no dependencies; imported by bfla_ctrl, bfla_out and the top level
`timescale 1ns / 1ps

package bfla_pkg;

    localparam int CNT_W    = 11;
    localparam int IDX_W    = 10;
    localparam int KEY_W    = 32;
    localparam int OWNER_W  = 8;
    localparam int REQ_W    = 6;
    localparam int SHORT_W  = 32;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 96;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_GRANTED     = 2'd0,
        ST_SHORT       = 2'd1,
        ST_PUT_OK      = 2'd2,
        ST_PUT_REFUSED = 2'd3
    } t_status;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [KEY_W-1:0]   key;
        logic [OWNER_W-1:0] owner;
        logic               last;
        t_status            status;
        logic [CNT_W-1:0]   free;
        logic [SHORT_W-1:0] shortage;
    } t_result;

endpackage

[design/bfla_ram.sv]
// bfla_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module bfla_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/bfla_ctrl.sv]
// bfla_ctrl: request sequencer, free count, low-water mark and the free stack ram
// depends on bfla_pkg and bfla_ram
`timescale 1ns / 1ps

module bfla_ctrl #(
    parameter int POOL_DEPTH = 1024,
    parameter int MAX_BATCH  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [bfla_pkg::CNT_W-1:0]     i_cfg_wr_data,
    input  logic                           i_req_valid,
    output logic                           o_req_ready,
    input  logic                           i_opcode,
    input  logic [bfla_pkg::REQ_W-1:0]     i_req_count,
    input  logic [bfla_pkg::IDX_W-1:0]     i_ret_idx,
    input  logic [bfla_pkg::KEY_W-1:0]     i_key,
    input  logic [bfla_pkg::OWNER_W-1:0]   i_owner,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output bfla_pkg::t_result              o_res
);

    import bfla_pkg::*;

    // positions above 2047 are never reached with an 11-bit pool size
    localparam int STACK_DEPTH = (POOL_DEPTH < 2048) ? POOL_DEPTH : 2048;
    localparam int AW          = $clog2(STACK_DEPTH);
    localparam logic [CNT_W-1:0] POOL_LIMIT =
        CNT_W'((POOL_DEPTH < 2047) ? POOL_DEPTH : 2047);
    localparam logic [CNT_W-1:0] POOL_RESET =
        CNT_W'((POOL_DEPTH < 1024) ? POOL_DEPTH : 1024);
    localparam logic [REQ_W-1:0] BATCH_LIMIT =
        REQ_W'((MAX_BATCH < 63) ? MAX_BATCH : 63);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EMIT  = 2'd1;
    localparam logic [1:0] S_GRD   = 2'd2;
    localparam logic [1:0] S_GWAIT = 2'd3;

    logic [1:0]         r_state,  n_state;
    logic [CNT_W-1:0]   r_pool,   n_pool;
    logic [CNT_W-1:0]   r_free,   n_free;
    logic [CNT_W-1:0]   r_low,    n_low;
    logic [SHORT_W-1:0] r_short,  n_short;
    logic [REQ_W-1:0]   r_remain, n_remain;
    logic [KEY_W-1:0]   r_key,    n_key;
    logic [OWNER_W-1:0] r_owner,  n_owner;
    logic [CNT_W-1:0]   r_pos,    n_pos;
    logic               r_from_mem, n_from_mem;
    t_result            r_pend,   n_pend;

    logic               accept;
    logic [REQ_W-1:0]   count_sat;
    logic [CNT_W-1:0]   cfg_sat;
    logic [CNT_W-1:0]   pop_pos;
    logic [SHORT_W-1:0] short_inc;

    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic [IDX_W-1:0]   ram_rd_data;

    bfla_ram #(
        .WIDTH (IDX_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (i_ret_idx),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign count_sat   = (i_req_count > BATCH_LIMIT) ? BATCH_LIMIT : i_req_count;
    assign cfg_sat     = (i_cfg_wr_data > POOL_LIMIT) ? POOL_LIMIT : i_cfg_wr_data;
    assign pop_pos     = r_free - CNT_W'(1);
    assign short_inc   = (r_short == '1) ? r_short : r_short + SHORT_W'(1);
    assign ram_wr_addr = r_free[AW-1:0];
    assign ram_rd_addr = pop_pos[AW-1:0];

    always_comb begin
        n_state    = r_state;
        n_pool     = r_pool;
        n_free     = r_free;
        n_low      = r_low;
        n_short    = r_short;
        n_remain   = r_remain;
        n_key      = r_key;
        n_owner    = r_owner;
        n_pos      = r_pos;
        n_from_mem = r_from_mem;
        n_pend     = r_pend;
        ram_wr_en  = 1'b0;
        ram_rd_en  = 1'b0;
        o_res_valid = 1'b0;
        o_res       = r_pend;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pend          = '0;
                    n_pend.last     = 1'b1;
                    n_pend.shortage = r_short;
                    n_pend.free     = r_free;
                    if (i_opcode == OP_PUT) begin
                        n_state = S_EMIT;
                        if (r_free >= r_pool) begin
                            n_pend.status = ST_PUT_REFUSED;
                        end else begin
                            ram_wr_en     = 1'b1;
                            n_free        = r_free + CNT_W'(1);
                            n_pend.free   = r_free + CNT_W'(1);
                            n_pend.status = ST_PUT_OK;
                        end
                    end else if (count_sat == '0) begin
                        n_state = S_IDLE;
                    end else if (r_free < CNT_W'(count_sat)) begin
                        n_state         = S_EMIT;
                        n_short         = short_inc;
                        n_pend.shortage = short_inc;
                        n_pend.status   = ST_SHORT;
                    end else begin
                        n_state  = S_GRD;
                        n_remain = count_sat;
                        n_key    = i_key;
                        n_owner  = i_owner;
                    end
                end
            end
            S_EMIT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_GRD: begin
                // entries below the low-water mark still hold their own position
                ram_rd_en  = 1'b1;
                n_free     = pop_pos;
                n_pos      = pop_pos;
                n_from_mem = (pop_pos >= r_low);
                if (pop_pos < r_low) begin
                    n_low = pop_pos;
                end
                n_remain = r_remain - REQ_W'(1);
                n_state  = S_GWAIT;
            end
            S_GWAIT: begin
                o_res_valid    = 1'b1;
                o_res.idx      = r_from_mem ? ram_rd_data : r_pos[IDX_W-1:0];
                o_res.key      = r_key;
                o_res.owner    = r_owner;
                o_res.last     = (r_remain == '0);
                o_res.status   = ST_GRANTED;
                o_res.free     = r_free;
                o_res.shortage = r_short;
                if (i_res_ready) begin
                    n_state = (r_remain == '0) ? S_IDLE : S_GRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a pool size write refills the stack by resetting the low-water mark
        if (i_cfg_wr_en) begin
            n_pool = cfg_sat;
            n_free = cfg_sat;
            n_low  = cfg_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pool  <= POOL_RESET;
            r_free  <= POOL_RESET;
            r_low   <= POOL_RESET;
            r_short <= '0;
        end else begin
            r_state <= n_state;
            r_pool  <= n_pool;
            r_free  <= n_free;
            r_low   <= n_low;
            r_short <= n_short;
        end
    end

    always_ff @(posedge i_clk) begin
        r_remain   <= n_remain;
        r_key      <= n_key;
        r_owner    <= n_owner;
        r_pos      <= n_pos;
        r_from_mem <= n_from_mem;
        r_pend     <= n_pend;
    end

    a_free_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= r_pool)
        else $error("free count above pool size");

    a_low_below_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_free)
        else $error("low-water mark above free count");

    a_put_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == OP_PUT && r_free < r_pool && !i_cfg_wr_en)
        |=> (r_free == $past(r_free) + CNT_W'(1)))
        else $error("accepted put did not grow the stack");

    a_grant_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GWAIT && i_res_ready && r_remain != '0) |=> (r_state == S_GRD))
        else $error("batch stopped before its last grant");

endmodule

[design/bfla_out.sv]
// bfla_out: output register of the result stream, packs results onto the bus
// depends on bfla_pkg
`timescale 1ns / 1ps

module bfla_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  bfla_pkg::t_result             i_res,
    output logic                          o_free,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic [bfla_pkg::M_DATA_W-1:0] o_tdata,
    output logic [1:0]                    o_tuser,
    output logic                          o_tlast
);

    import bfla_pkg::*;

    localparam int PAD_W = M_DATA_W - (IDX_W + KEY_W + OWNER_W + CNT_W + SHORT_W);

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {PAD_W'(0), r_res.shortage, r_res.free, r_res.owner,
                       r_res.key, r_res.idx};
    assign o_tuser  = r_res.status;
    assign o_tlast  = r_res.last;

endmodule

[design/buffer_free_list_allocator.sv]
// buffer_free_list_allocator: top level of the lifo buffer free-list allocator
// depends on bfla_pkg, bfla_ctrl, bfla_out (and bfla_ram through bfla_ctrl)
//
// channel    | dir | handshake                        | contents
// -----------+-----+----------------------------------+-------------------------------
// s_axis     | in  | i_s_axis_tvalid/o_s_axis_tready  | get or put request item
// m_axis     | out | o_m_axis_tvalid/i_m_axis_tready  | grant or status item, tlast ends run
// cfg        | in  | i_cfg_wr_en                      | pool_size write, refills stack
//
// a put or a refused get goes from idle straight to the output state; a get of n buffers
// takes one free-stack ram read and one output load per grant.
// the output register takes the next item only when it is empty or its result is taken.
// reset is synchronous, active low; the stack needs no clearing pass, a low-water
// mark makes untouched entries read as their own position.
// a stalled m_axis holds the sequencer in its output state until the item is taken.
`timescale 1ns / 1ps

module buffer_free_list_allocator #(
    parameter int POOL_DEPTH = 1024,
    parameter int MAX_BATCH  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [bfla_pkg::CNT_W-1:0]    i_cfg_wr_data,   // pool_size
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // request_count[5:0], return_index[15:6], key_value[47:16], owner_tag[55:48]
    input  logic [bfla_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    input  logic                          i_s_axis_tuser,  // opcode
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // granted_index[9:0], granted_key[41:10], granted_owner[49:42],
    // free_remaining[60:50], shortage_events[92:61], zero[95:93]
    output logic [bfla_pkg::M_DATA_W-1:0] o_m_axis_tdata,
    output logic [1:0]                    o_m_axis_tuser,  // status[1:0]
    output logic                          o_m_axis_tlast   // last_of_run
);

    import bfla_pkg::*;

    logic    res_valid;
    logic    res_ready;
    t_result res;

    bfla_ctrl #(
        .POOL_DEPTH (POOL_DEPTH),
        .MAX_BATCH  (MAX_BATCH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req_valid   (i_s_axis_tvalid),
        .o_req_ready   (o_s_axis_tready),
        .i_opcode      (i_s_axis_tuser),
        .i_req_count   (i_s_axis_tdata[5:0]),
        .i_ret_idx     (i_s_axis_tdata[15:6]),
        .i_key         (i_s_axis_tdata[47:16]),
        .i_owner       (i_s_axis_tdata[55:48]),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res)
    );

    bfla_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_res    (res),
        .o_free   (res_ready),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (o_m_axis_tuser),
        .o_tlast  (o_m_axis_tlast)
    );

endmodule

[tb/testbench.sv]
// testbench: self-checking bench for the lifo buffer free-list allocator
// depends on bfla_pkg and buffer_free_list_allocator; drives get/put items and
// pool_size writes, predicts every grant and status item and compares them field by field
`timescale 1ns / 1ps

module testbench;
    import bfla_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int BATCH_MAX   = 32;
    localparam int SETTLE      = 80;
    localparam int HOLD_CYCLES = 300;
    localparam int PRINT_CAP   = 40;

    typedef struct packed {
        logic               op;
        logic [REQ_W-1:0]   count;
        logic [IDX_W-1:0]   ret;
        logic [KEY_W-1:0]   key;
        logic [OWNER_W-1:0] owner;
        logic               typed;
        t_result            want;
    } t_req;

    typedef enum logic {ROW_REQ, ROW_POOL} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [CNT_W-1:0] pool_val;
        t_req             req;
    } t_stim_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]    i_cfg_wr_data = '0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [S_DATA_W-1:0] i_s_axis_tdata = '0;
    logic                i_s_axis_tuser = 1'b0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_axis_tdata;
    logic [1:0]          o_m_axis_tuser;
    logic                o_m_axis_tlast;

    // predictor state
    logic [IDX_W-1:0] free_stack_p [DEPTH];
    int unsigned      free_cnt_p;
    int unsigned      pool_p;
    logic [31:0]      shortage_p;

    t_req             req_backlog [$];
    t_result          owed_results [$];
    logic [IDX_W-1:0] loaned_idx [$];
    t_stim_row        dir_table [$];

    t_req             offer_now;
    logic             offer_next;
    t_result          seen_res;
    t_result          owed_head;
    int unsigned      send_idle_pct = 0;
    int unsigned      recv_idle_pct = 0;
    bit               hold_request = 1'b0;
    int unsigned      hold_left = 0;
    int unsigned      err_count = 0;

    buffer_free_list_allocator i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < PRINT_CAP) begin
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        end
        err_count++;
    endtask

    function automatic void refill_pool(input logic [CNT_W-1:0] v);
        pool_p = (v > DEPTH) ? DEPTH : v;
        for (int i = 0; i < DEPTH; i++) begin
            free_stack_p[i] = i[IDX_W-1:0];
        end
        free_cnt_p = pool_p;
    endfunction

    // works out the items one accepted request causes and queues them
    function automatic void predict_alloc(input t_req r);
        int unsigned n;
        t_result     res;
        t_result     run_q [$];
        if (r.op == OP_PUT) begin
            res = '0;
            res.last = 1'b1;
            if (free_cnt_p >= pool_p || free_cnt_p >= DEPTH) begin
                res.status = ST_PUT_REFUSED;
            end else begin
                free_stack_p[free_cnt_p] = r.ret;
                free_cnt_p++;
                res.status = ST_PUT_OK;
            end
            res.free = CNT_W'(free_cnt_p);
            res.shortage = shortage_p;
            run_q = {run_q, res};
        end else begin
            n = (r.count > BATCH_MAX) ? BATCH_MAX : r.count;
            if (n != 0 && free_cnt_p < n) begin
                if (shortage_p != 32'hFFFF_FFFF) begin
                    shortage_p++;
                end
                res = '0;
                res.last = 1'b1;
                res.status = ST_SHORT;
                res.free = CNT_W'(free_cnt_p);
                res.shortage = shortage_p;
                run_q = {run_q, res};
            end else begin
                for (int unsigned k = 0; k < n; k++) begin
                    free_cnt_p--;
                    res = '0;
                    res.idx = free_stack_p[free_cnt_p];
                    res.key = r.key;
                    res.owner = r.owner;
                    res.last = (k + 1 == n);
                    res.status = ST_GRANTED;
                    res.free = CNT_W'(free_cnt_p);
                    res.shortage = shortage_p;
                    run_q = {run_q, res};
                end
            end
        end
        if (r.typed && run_q.size() > 0) begin
            run_q[run_q.size() - 1] = r.want;
        end
        foreach (run_q[i]) begin
            owed_results = {owed_results, run_q[i]};
        end
    endfunction

    function automatic void req_row(input logic op, input int cnt, input int ret,
                                    input logic [31:0] key, input logic [7:0] owner);
        t_stim_row row;
        row = '0;
        row.kind = ROW_REQ;
        row.req.op = op;
        row.req.count = cnt[REQ_W-1:0];
        row.req.ret = ret[IDX_W-1:0];
        row.req.key = key;
        row.req.owner = owner;
        dir_table = {dir_table, row};
    endfunction

    // request row whose single (or final) item is written out by hand
    function automatic void typed_row(input logic op, input int cnt, input int ret,
                                      input logic [31:0] key, input logic [7:0] owner,
                                      input t_status st, input int idx, input int free,
                                      input int shortage);
        t_result w;
        req_row(op, cnt, ret, key, owner);
        w = '0;
        w.idx = idx[IDX_W-1:0];
        w.key = (st == ST_GRANTED) ? key : '0;
        w.owner = (st == ST_GRANTED) ? owner : '0;
        w.last = 1'b1;
        w.status = st;
        w.free = free[CNT_W-1:0];
        w.shortage = shortage;
        dir_table[dir_table.size() - 1].req.typed = 1'b1;
        dir_table[dir_table.size() - 1].req.want = w;
    endfunction

    function automatic void pool_row(input logic [CNT_W-1:0] v);
        t_stim_row row;
        row = '0;
        row.kind = ROW_POOL;
        row.pool_val = v;
        dir_table = {dir_table, row};
    endfunction

    // mostly gets of a few buffers and puts of buffers handed out earlier,
    // steered so the stack neither stays empty nor stays full
    function automatic t_req random_req();
        t_req        r;
        int unsigned get_pct;
        int unsigned pick;
        r = '0;
        r.key = $urandom;
        r.owner = OWNER_W'($urandom_range(0, 255));
        r.ret = IDX_W'($urandom_range(0, DEPTH - 1));
        if ($urandom_range(0, 99) < 10) begin
            r.op = 1'($urandom_range(0, 1));
            r.count = REQ_W'($urandom_range(0, 63));
        end else begin
            if (free_cnt_p * 4 < pool_p) begin
                get_pct = 25;
            end else if (free_cnt_p * 4 > pool_p * 3) begin
                get_pct = 75;
            end else begin
                get_pct = 50;
            end
            if ($urandom_range(0, 99) < get_pct) begin
                r.op = OP_GET;
                r.count = ($urandom_range(0, 99) < 80) ? REQ_W'($urandom_range(1, 8))
                                                       : REQ_W'($urandom_range(1, BATCH_MAX));
            end else begin
                r.op = OP_PUT;
                if (loaned_idx.size() > 0 && $urandom_range(0, 99) < 85) begin
                    pick = $urandom_range(0, loaned_idx.size() - 1);
                    r.ret = loaned_idx[pick];
                    loaned_idx.delete(pick);
                end
            end
        end
        return r;
    endfunction

    task automatic wait_idle();
        while (req_backlog.size() != 0 || i_s_axis_tvalid || owed_results.size() != 0) begin
            @(negedge i_clk);
        end
        // an empty get leaves nothing to wait for, so give the sequencer time
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_pool(input logic [CNT_W-1:0] v);
        wait_idle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        refill_pool(v);
        loaned_idx.delete();
    endtask

    task automatic queue_req(input t_req r);
        while (req_backlog.size() >= 2) begin
            @(negedge i_clk);
        end
        req_backlog = {req_backlog, r};
    endtask

    task automatic run_phase(input logic [CNT_W-1:0] pool_v, input int n_items,
                             input int s_pct, input int r_pct, input bit hold);
        int   made;
        t_req r;
        made = 0;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        write_pool(pool_v);
        @(negedge i_clk);
        hold_request = hold;
        while (made < n_items) begin
            r = random_req();
            queue_req(r);
            if (!(r.op == OP_GET && r.count == 0)) begin
                made++;
            end
            @(negedge i_clk);
        end
    endtask

    // request side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            offer_next = i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_alloc(offer_now);
                offer_next = 1'b0;
            end
            if (!offer_next && req_backlog.size() > 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                offer_now = req_backlog.pop_front();
                offer_next = 1'b1;
                i_s_axis_tdata <= {offer_now.owner, offer_now.key, offer_now.ret,
                                   offer_now.count};
                i_s_axis_tuser <= offer_now.op;
            end
            i_s_axis_tvalid <= offer_next;
        end
    end

    // result side ready, with one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen_res = '0;
            seen_res.idx = o_m_axis_tdata[9:0];
            seen_res.key = o_m_axis_tdata[41:10];
            seen_res.owner = o_m_axis_tdata[49:42];
            seen_res.free = o_m_axis_tdata[60:50];
            seen_res.shortage = o_m_axis_tdata[92:61];
            seen_res.status = t_status'(o_m_axis_tuser);
            seen_res.last = o_m_axis_tlast;
            if (owed_results.size() == 0) begin
                report_mismatch("unexpected item, status", 32'(o_m_axis_tuser), 32'd0);
            end else begin
                owed_head = owed_results.pop_front();
                if (seen_res.idx !== owed_head.idx)
                    report_mismatch("granted_index", 32'(seen_res.idx), 32'(owed_head.idx));
                if (seen_res.key !== owed_head.key)
                    report_mismatch("granted_key", seen_res.key, owed_head.key);
                if (seen_res.owner !== owed_head.owner)
                    report_mismatch("granted_owner", 32'(seen_res.owner),
                                    32'(owed_head.owner));
                if (seen_res.last !== owed_head.last)
                    report_mismatch("last_of_run", 32'(seen_res.last), 32'(owed_head.last));
                if (seen_res.status !== owed_head.status)
                    report_mismatch("status", 32'(seen_res.status), 32'(owed_head.status));
                if (seen_res.free !== owed_head.free)
                    report_mismatch("free_remaining", 32'(seen_res.free),
                                    32'(owed_head.free));
                if (seen_res.shortage !== owed_head.shortage)
                    report_mismatch("shortage_events", seen_res.shortage, owed_head.shortage);
                if (owed_head.status == ST_GRANTED) begin
                    loaned_idx = {loaned_idx, owed_head.idx};
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

    initial begin
        shortage_p = '0;
        refill_pool(DEPTH);

        // after reset the pool is full with the highest index on top
        typed_row(OP_GET, 1, 0, 32'hFFFF_FFFF, 8'hFF, ST_GRANTED, 1023, 1023, 0);
        typed_row(OP_PUT, 0, 1023, 32'h0, 8'h0, ST_PUT_OK, 0, 1024, 0);
        typed_row(OP_PUT, 0, 0, 32'hFFFF_FFFF, 8'hFF, ST_PUT_REFUSED, 0, 1024, 0);
        req_row(OP_GET, 0, 0, 32'h1234_5678, 8'h56);           // empty get
        req_row(OP_GET, 63, 1023, 32'h0, 8'h0);                // saturates to a full batch
        req_row(OP_GET, 32, 0, 32'hA5A5_A5A5, 8'h5A);
        req_row(OP_PUT, 0, 1023, 32'h0, 8'h0);
        req_row(OP_PUT, 0, 5, 32'h0, 8'h0);                    // index already free
        req_row(OP_GET, 2, 0, 32'h0F0F_0F0F, 8'hF0);
        req_row(OP_GET, 33, 0, 32'hFFFF_FFFF, 8'hFF);
        req_row(OP_GET, 1, 682, 32'h5A5A_5A5A, 8'hA5);
        pool_row(11'd0);
        typed_row(OP_GET, 1, 0, 32'hDEAD_BEEF, 8'h11, ST_SHORT, 0, 0, 1);
        typed_row(OP_PUT, 0, 682, 32'h0, 8'h0, ST_PUT_REFUSED, 0, 0, 1);
        typed_row(OP_GET, 32, 0, 32'h0, 8'h0, ST_SHORT, 0, 0, 2);
        pool_row(11'd2047);                                    // clips to the full depth
        req_row(OP_GET, 32, 1023, 32'h0, 8'h0);
        req_row(OP_PUT, 0, 341, 32'h0, 8'h0);
        pool_row(11'd2);
        typed_row(OP_GET, 3, 0, 32'h0, 8'h0, ST_SHORT, 0, 2, 3);
        req_row(OP_GET, 2, 0, 32'h8000_0001, 8'h80);
        typed_row(OP_GET, 1, 0, 32'h0, 8'h0, ST_SHORT, 0, 0, 4);
        req_row(OP_PUT, 0, 7, 32'h0, 8'h0);
        req_row(OP_PUT, 0, 8, 32'h0, 8'h0);
        typed_row(OP_PUT, 0, 9, 32'h0, 8'h0, ST_PUT_REFUSED, 0, 2, 4);
        pool_row(11'd1);
        typed_row(OP_GET, 1, 0, 32'hC3C3_C3C3, 8'h3C, ST_GRANTED, 0, 0, 4);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 27;
        recv_idle_pct = 66;
        foreach (dir_table[i]) begin
            if (dir_table[i].kind == ROW_POOL) begin
                write_pool(dir_table[i].pool_val);
            end else begin
                queue_req(dir_table[i].req);
            end
        end

        run_phase(11'd1024, 120, 27, 66, 1'b0);
        run_phase(CNT_W'($urandom_range(1, 64)), 120, 66, 27, 1'b0);
        run_phase(11'd0, 15, 66, 27, 1'b0);
        run_phase(CNT_W'($urandom_range(65, 1024)), 150, 0, 0, 1'b1);
        run_phase(11'd1, 40, 0, 0, 1'b0);

        wait_idle();
        if (err_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
